// ----- src/wep_pkg.sv -----
// Package with constants, payload types and stage control type for the water equilibrium core.
package wep_pkg;

  localparam int CONC_W  = 56;
  localparam int OUT_W   = CONC_W - 1;
  localparam int KW_W    = 64;
  localparam int SQ_W    = (2 * CONC_W > KW_W + 4) ? 2 * CONC_W : KW_W + 4;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int LO_W    = OUT_W / 2;
  localparam int HI_W    = OUT_W - LO_W;
  localparam int DREM_W  = OUT_W + 1;

  localparam logic [KW_W-1:0]  KW_RESET = 64'd4835703278458516699;
  localparam logic [OUT_W-1:0] OUT_MAX  = {OUT_W{1'b1}};

  typedef struct packed {
    logic signed [CONC_W-1:0] hydrogen_in;
    logic signed [CONC_W-1:0] hydroxide_in;
  } in_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] hydrogen_out;
    logic [OUT_W-1:0] hydroxide_out;
    logic             saturated;
  } out_req_t;

  typedef struct packed {
    logic a_nonneg;
    logic sat;
  } ctl_t;

endpackage

// ----- src/water_equilibrium_projection_core.sv -----
// Pipelined projection of hydrogen and hydroxide concentrations onto water equilibrium.
//
//  port group | direction | handshake       | payload
//  in_        | input     | valid / ready   | wep_pkg::in_req_t
//  out_       | output    | valid / ready   | wep_pkg::out_req_t
//  cfg_       | input     | write enable    | Kw, 64 bits
//
// One request enters every cycle unless the pipeline holds; the pipeline depth is set by the
// one-bit-per-stage square root and the one-bit-per-stage divider.
// Reset clears the valid bits of every stage and loads the reset Kw.
// The whole pipeline holds while the output register is full and not taken; nothing is lost.
module water_equilibrium_projection_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wep_pkg::in_req_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wep_pkg::out_req_t           out_data,
  input  logic                        cfg_we,
  input  logic [wep_pkg::KW_W-1:0]    cfg_wdata
);

  localparam int CW = wep_pkg::CONC_W;
  localparam int OW = wep_pkg::OUT_W;
  localparam int KW = wep_pkg::KW_W;
  localparam int SW = wep_pkg::SQ_W;
  localparam int RW = wep_pkg::ROOT_W;
  localparam int EW = wep_pkg::REM_W;
  localparam int LW = wep_pkg::LO_W;
  localparam int HW = wep_pkg::HI_W;
  localparam int DW = wep_pkg::DREM_W;

  logic          en;
  logic [KW-1:0] kw_r;

  // Input register.
  logic                 v0_r;
  wep_pkg::in_req_t     in0_r;
  // Difference and magnitude.
  logic                 v1_r;
  wep_pkg::ctl_t        c1_r;
  logic [OW-1:0]        mag1_r;
  // Partial products.
  logic                 v2_r;
  wep_pkg::ctl_t        c2_r;
  logic [OW-1:0]        mag2_r;
  logic [2*LW-1:0]      pll_r;
  logic [LW+HW-1:0]     plh_r;
  logic [LW+HW-1:0]     phl_r;
  logic [2*HW-1:0]      phh_r;
  // Square root stages, index 0 is the radicand stage.
  logic                 sv_r   [RW+1];
  wep_pkg::ctl_t        sc_r   [RW+1];
  logic [OW-1:0]        smag_r [RW+1];
  logic [SW-1:0]        ss_r   [RW+1];
  logic [EW-1:0]        srem_r [RW+1];
  logic [RW-1:0]        sq_r   [RW+1];
  // Divider stages, index 0 holds the larger value.
  logic                 dv_r   [KW+1];
  wep_pkg::ctl_t        dc_r   [KW+1];
  logic [OW-1:0]        dl_r   [KW+1];
  logic [DW-1:0]        drem_r [KW+1];
  logic [KW-1:0]        dd_r   [KW+1];
  logic [KW-1:0]        dq_r   [KW+1];
  // Output register.
  logic                 ov_r;
  wep_pkg::out_req_t    out_r;

  logic signed [CW:0]   diff;
  logic [CW:0]          mag_full;
  logic [SW-1:0]        rad;
  logic [RW:0]          lsum;
  logic [RW-1:0]        lval;
  logic                 lsat;
  logic [OW-1:0]        sm_val;
  logic [OW-1:0]        lg_val;

  assign en       = !ov_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_r <= wep_pkg::KW_RESET;
    end else if (cfg_we) begin
      kw_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r     <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      sv_r[0]  <= 1'b0;
      dv_r[0]  <= 1'b0;
      ov_r     <= 1'b0;
    end else if (en) begin
      v0_r     <= in_valid;
      v1_r     <= v0_r;
      v2_r     <= v1_r;
      sv_r[0]  <= v2_r;
      dv_r[0]  <= sv_r[RW];
      ov_r     <= dv_r[KW];
    end
  end

  assign diff     = {in0_r.hydrogen_in[CW-1], in0_r.hydrogen_in}
                  - {in0_r.hydroxide_in[CW-1], in0_r.hydroxide_in};
  assign mag_full = diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);

  assign rad = (SW'(phh_r) << (2 * LW)) + (SW'(plh_r) << LW) + (SW'(phl_r) << LW)
             + SW'(pll_r) + (SW'(kw_r) << 2);

  assign lsum = (RW+1)'(smag_r[RW]) + (RW+1)'(sq_r[RW]);
  assign lval = lsum[RW:1];
  assign lsat = sc_r[RW].sat || (lval > RW'(wep_pkg::OUT_MAX));

  always_ff @(posedge clk) begin
    if (en) begin
      in0_r      <= in_data;
      c1_r.a_nonneg <= !diff[CW];
      c1_r.sat   <= (mag_full[CW:OW] != '0);
      mag1_r     <= mag_full[OW-1:0];
      c2_r       <= c1_r;
      mag2_r     <= mag1_r;
      pll_r      <= mag1_r[LW-1:0] * mag1_r[LW-1:0];
      plh_r      <= mag1_r[LW-1:0] * mag1_r[OW-1:LW];
      phl_r      <= mag1_r[OW-1:LW] * mag1_r[LW-1:0];
      phh_r      <= mag1_r[OW-1:LW] * mag1_r[OW-1:LW];
      sc_r[0]    <= c2_r;
      smag_r[0]  <= mag2_r;
      ss_r[0]    <= rad;
      srem_r[0]  <= '0;
      sq_r[0]    <= '0;
      dc_r[0].a_nonneg <= sc_r[RW].a_nonneg;
      dc_r[0].sat      <= lsat;
      dl_r[0]    <= lsat ? wep_pkg::OUT_MAX : lval[OW-1:0];
      drem_r[0]  <= '0;
      dd_r[0]    <= kw_r;
      dq_r[0]    <= '0;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [EW-1:0] rsh;
    logic [EW-1:0] trial;
    logic          take;
    assign rsh   = {srem_r[k][EW-3:0], ss_r[k][SW-1:SW-2]};
    assign trial = EW'({sq_r[k], 2'b01});
    assign take  = rsh >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (en) begin
        sv_r[k+1] <= sv_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sc_r[k+1]   <= sc_r[k];
        smag_r[k+1] <= smag_r[k];
        ss_r[k+1]   <= ss_r[k] << 2;
        srem_r[k+1] <= take ? rsh - trial : rsh;
        sq_r[k+1]   <= {sq_r[k][RW-2:0], take};
      end
    end
  end

  for (genvar j = 0; j < KW; j++) begin : g_div
    logic [DW-1:0] rsh;
    logic          take;
    assign rsh  = {drem_r[j][DW-2:0], dd_r[j][KW-1]};
    assign take = rsh >= DW'(dl_r[j]);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_r[j+1] <= dv_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dc_r[j+1]   <= dc_r[j];
        dl_r[j+1]   <= dl_r[j];
        drem_r[j+1] <= take ? rsh - DW'(dl_r[j]) : rsh;
        dd_r[j+1]   <= dd_r[j] << 1;
        dq_r[j+1]   <= {dq_r[j][KW-2:0], take};
      end
    end
  end

  assign lg_val = dl_r[KW];
  assign sm_val = (lg_val == '0) ? '0 :
                  (dq_r[KW] > KW'(wep_pkg::OUT_MAX)) ? wep_pkg::OUT_MAX : dq_r[KW][OW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.hydrogen_out  <= dc_r[KW].a_nonneg ? lg_val : sm_val;
      out_r.hydroxide_out <= dc_r[KW].a_nonneg ? sm_val : lg_val;
      out_r.saturated     <= dc_r[KW].sat;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the water equilibrium projection core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CONC_W = wep_pkg::CONC_W;
  localparam int OUT_W = wep_pkg::OUT_W;
  localparam int KW_W = wep_pkg::KW_W;
  localparam int LATENCY = wep_pkg::ROOT_W + wep_pkg::KW_W + 5;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [CONC_W-1:0] C_MAX = {1'b0, {(CONC_W-1){1'b1}}};
  localparam logic [CONC_W-1:0] C_MIN = {1'b1, {(CONC_W-1){1'b0}}};
  localparam logic [KW_W-1:0] KW_TOP = {KW_W{1'b1}};

  typedef struct {
    wep_pkg::in_req_t  req;
    bit                typed;
    wep_pkg::out_req_t want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  wep_pkg::in_req_t    in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  wep_pkg::out_req_t   out_data;
  logic                cfg_we = 1'b0;
  logic [KW_W-1:0]     cfg_wdata = '0;

  logic [KW_W-1:0]     kw_now = wep_pkg::KW_RESET;
  wep_pkg::out_req_t   pending_eq[$];
  row_t                rows[$];
  int                  errors = 0;
  int                  cycles = 0;
  int                  idle_pct = 0;
  int                  stall_pct = 0;

  water_equilibrium_projection_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic wep_pkg::out_req_t project(wep_pkg::in_req_t r, logic [KW_W-1:0] kw);
    logic signed [CONC_W:0] diff;
    logic [63:0]            mag;
    logic [127:0]           s;
    logic [63:0]            root;
    logic [63:0]            c;
    logic [64:0]            sum;
    logic [64:0]            big;
    logic [63:0]            small_c;
    bit                     nonneg;
    bit                     sat;
    wep_pkg::out_req_t      o;
    diff = {r.hydrogen_in[CONC_W-1], r.hydrogen_in} - {r.hydroxide_in[CONC_W-1], r.hydroxide_in};
    nonneg = (diff >= 0);
    mag = nonneg ? 64'(diff) : 64'(-diff);
    sat = 1'b0;
    if (mag > 64'(wep_pkg::OUT_MAX)) begin
      big = 65'(wep_pkg::OUT_MAX);
      sat = 1'b1;
    end else begin
      s = {64'b0, mag} * {64'b0, mag} + ({64'b0, kw} << 2);
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        c = root | (64'd1 << b);
        if ({64'b0, c} * {64'b0, c} <= s) root = c;
      end
      sum = {1'b0, mag} + {1'b0, root};
      big = sum >> 1;
      if (big > 65'(wep_pkg::OUT_MAX)) begin
        big = 65'(wep_pkg::OUT_MAX);
        sat = 1'b1;
      end
    end
    small_c = (big == 0) ? 64'd0 : 64'(kw / big[63:0]);
    if (small_c > 64'(wep_pkg::OUT_MAX)) small_c = 64'(wep_pkg::OUT_MAX);
    o.hydrogen_out  = nonneg ? big[OUT_W-1:0] : small_c[OUT_W-1:0];
    o.hydroxide_out = nonneg ? small_c[OUT_W-1:0] : big[OUT_W-1:0];
    o.saturated     = sat;
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycles, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && in_valid && in_ready) pending_eq.push_back(project(in_data, kw_now));
    if (rst_n && out_valid && out_ready) begin
      if (pending_eq.size() == 0) begin
        $display("unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        wep_pkg::out_req_t e;
        e = pending_eq.pop_front();
        if (out_data.hydrogen_out !== e.hydrogen_out)
          report_mismatch("hydrogen_out", 64'(out_data.hydrogen_out), 64'(e.hydrogen_out));
        if (out_data.hydroxide_out !== e.hydroxide_out)
          report_mismatch("hydroxide_out", 64'(out_data.hydroxide_out), 64'(e.hydroxide_out));
        if (out_data.saturated !== e.saturated)
          report_mismatch("saturated", 64'(out_data.saturated), 64'(e.saturated));
      end
    end
    if (cycles >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send(wep_pkg::in_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_eq.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_kw(logic [KW_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    kw_now = v;
    @(posedge clk);
  endtask

  function automatic logic [CONC_W-1:0] rand_scaled();
    logic [63:0] v;
    v = {$urandom, $urandom} >> $urandom_range(8, 63);
    return $urandom_range(1) ? CONC_W'(v) : CONC_W'(-v);
  endfunction

  function automatic wep_pkg::in_req_t rand_req();
    wep_pkg::in_req_t r;
    logic [CONC_W-1:0] d;
    case ($urandom_range(4))
      0: begin
        r.hydrogen_in  = CONC_W'({$urandom, $urandom});
        r.hydroxide_in = CONC_W'({$urandom, $urandom});
      end
      1, 2: begin
        r.hydroxide_in = rand_scaled();
        d = CONC_W'($urandom_range(0, 3)) - CONC_W'(2);
        r.hydrogen_in = $urandom_range(1) ? rand_scaled() : r.hydroxide_in + d;
      end
      3: begin
        d = C_MAX - CONC_W'($urandom_range(0, 3)) + CONC_W'($urandom_range(0, 3));
        r.hydroxide_in = CONC_W'($signed(rand_scaled()) >>> 2);
        r.hydrogen_in  = $urandom_range(1) ? r.hydroxide_in + d : r.hydroxide_in - d;
      end
      default: begin
        r.hydrogen_in  = $urandom_range(1) ? C_MAX : C_MIN;
        r.hydroxide_in = $urandom_range(1) ? rand_scaled() : ($urandom_range(1) ? C_MAX : C_MIN);
      end
    endcase
    return r;
  endfunction

  function automatic row_t mk(logic [CONC_W-1:0] h, logic [CONC_W-1:0] oh, bit typed,
                              logic [OUT_W-1:0] eh, logic [OUT_W-1:0] eoh, bit es);
    row_t t;
    t.req.hydrogen_in = h;
    t.req.hydroxide_in = oh;
    t.typed = typed;
    t.want.hydrogen_out = eh;
    t.want.hydroxide_out = eoh;
    t.want.saturated = es;
    return t;
  endfunction

  initial begin
    logic [KW_W-1:0] kw_set[7];
    int              idle_set[4];
    int              stall_set[4];

    idle_set  = '{0, 61, 0, 38};
    stall_set = '{0, 0, 61, 38};
    kw_set = '{64'd1, KW_TOP, 64'd0, {$urandom, $urandom},
               64'({$urandom, $urandom} >> $urandom_range(1, 40)),
               wep_pkg::KW_RESET, {$urandom, $urandom} >> 20};

    rows.push_back(mk(C_MAX, C_MIN, 1, wep_pkg::OUT_MAX, 55'd134, 1'b1));
    rows.push_back(mk(C_MIN, C_MAX, 1, 55'd134, wep_pkg::OUT_MAX, 1'b1));
    rows.push_back(mk('0, '0, 0, '0, '0, 0));
    rows.push_back(mk(C_MAX, C_MAX, 0, '0, '0, 0));
    rows.push_back(mk(C_MIN, C_MIN, 0, '0, '0, 0));
    rows.push_back(mk(C_MAX, '0, 0, '0, '0, 0));
    rows.push_back(mk('0, C_MAX, 0, '0, '0, 0));
    rows.push_back(mk(C_MIN, '0, 0, '0, '0, 0));
    rows.push_back(mk('0, C_MIN, 0, '0, '0, 0));
    rows.push_back(mk(CONC_W'(1), '0, 0, '0, '0, 0));
    rows.push_back(mk('0, CONC_W'(1), 0, '0, '0, 0));
    rows.push_back(mk({CONC_W{1'b1}}, {CONC_W{1'b1}}, 0, '0, '0, 0));
    rows.push_back(mk({CONC_W{1'b1}}, CONC_W'(1), 0, '0, '0, 0));
    rows.push_back(mk(CONC_W'(64'd1 << 44), CONC_W'(64'd1 << 44), 0, '0, '0, 0));
    rows.push_back(mk(CONC_W'(64'd1 << 30), '0, 0, '0, '0, 0));
    rows.push_back(mk(-CONC_W'(64'd1 << 30), CONC_W'(64'd1 << 20), 0, '0, '0, 0));
    rows.push_back(mk(C_MAX - CONC_W'(1), '0, 0, '0, '0, 0));
    rows.push_back(mk(C_MAX, -CONC_W'(1), 0, '0, '0, 0));
    rows.push_back(mk(-CONC_W'(1), C_MAX, 0, '0, '0, 0));
    rows.push_back(mk(C_MIN + CONC_W'(1), CONC_W'(1), 0, '0, '0, 0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send(rows[i].req);
      if (rows[i].typed && project(rows[i].req, kw_now) != rows[i].want) begin
        $display("table row %0d disagrees with the prediction", i);
        errors++;
      end
    end
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_kw(kw_set[ph]);
      idle_pct = idle_set[ph % 4];
      stall_pct = stall_set[ph % 4];
      for (int n = 0; n < 120; n++) begin
        if (n >= 40 && n < 60) begin
          idle_pct = 0;
          stall_pct = 0;
        end else begin
          idle_pct = idle_set[ph % 4];
          stall_pct = stall_set[ph % 4];
        end
        send(rand_req());
      end
      idle_pct = 0;
      stall_pct = 0;
      drain();
    end

    repeat (LATENCY) @(posedge clk);
    if (errors == 0 && pending_eq.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
